>>> hw/rtl/zsbf_pkg.sv
// zsbf_pkg: shared types, constants and phase helpers of the zlib stored-block framer
// no dependencies

package zsbf_pkg;

	localparam logic [15:0] ZSBF_BLOCK_BYTES = 16'd65535;
	localparam logic [16:0] ADLER_MOD        = 17'd65521;
	localparam logic [7:0]  ZLIB_CMF         = 8'h78;
	localparam logic [7:0]  ZLIB_FLG         = 8'h01;
	localparam logic [7:0]  BFINAL_SET       = 8'h01;
	localparam logic [7:0]  BFINAL_CLEAR     = 8'h00;

	// position of the byte being sent within one item's burst
	typedef enum logic [11:0] {
		PH_HDR0  = 12'b0000_0000_0001,
		PH_HDR1  = 12'b0000_0000_0010,
		PH_FLAG  = 12'b0000_0000_0100,
		PH_LEN0  = 12'b0000_0000_1000,
		PH_LEN1  = 12'b0000_0001_0000,
		PH_NLEN0 = 12'b0000_0010_0000,
		PH_NLEN1 = 12'b0000_0100_0000,
		PH_DATA  = 12'b0000_1000_0000,
		PH_ADL3  = 12'b0001_0000_0000,
		PH_ADL2  = 12'b0010_0000_0000,
		PH_ADL1  = 12'b0100_0000_0000,
		PH_ADL0  = 12'b1000_0000_0000
	} phase_t;

	// everything one input item makes the framer emit
	typedef struct packed {
		logic        shdr;    // zlib stream header due
		logic        bhdr;    // stored block header due
		logic        bfinal;  // block header marks the final block
		logic [15:0] len;
		logic [7:0]  data;
		logic        trailer; // adler-32 trailer follows the data byte
		logic [15:0] adl_hi;
		logic [15:0] adl_lo;
	} burst_t;

	function automatic phase_t first_phase(burst_t b);
		phase_t ph;
		if (b.shdr)
			ph = PH_HDR0;
		else if (b.bhdr)
			ph = PH_FLAG;
		else
			ph = PH_DATA;
		return ph;
	endfunction

	function automatic phase_t next_phase(phase_t ph, burst_t b);
		phase_t nx;
		unique case (ph)
			PH_HDR0:  nx = PH_HDR1;
			PH_HDR1:  nx = b.bhdr ? PH_FLAG : PH_DATA;
			PH_FLAG:  nx = PH_LEN0;
			PH_LEN0:  nx = PH_LEN1;
			PH_LEN1:  nx = PH_NLEN0;
			PH_NLEN0: nx = PH_NLEN1;
			PH_NLEN1: nx = PH_DATA;
			PH_DATA:  nx = PH_ADL3;
			PH_ADL3:  nx = PH_ADL2;
			PH_ADL2:  nx = PH_ADL1;
			PH_ADL1:  nx = PH_ADL0;
			default:  nx = PH_HDR0;
		endcase
		return nx;
	endfunction

endpackage

>>> hw/rtl/zsbf_if.sv
// zsbf_if: valid/ready channel interfaces for the raw byte input and the zlib output
// no dependencies

interface zsbf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface zsbf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_end;

	modport source (output valid, output out_byte, output run_last, output stream_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input stream_end,
		output ready);
endinterface

>>> hw/rtl/zlib_stored_block_framer.sv
// zlib_stored_block_framer: wraps raw bytes into a zlib stream of stored deflate blocks
// depends on zsbf_pkg and the channel interfaces in zsbf_if.sv

// One raw byte in, one to twelve stream bytes out, one output byte per cycle while the
// sink is ready. An accepted item is framed in the same cycle (stream header, block
// header, adler-32 update, trailer) and parked in a one-entry input stage; a sequencer
// stage then sends its bytes. Mid-block, input runs at one item per cycle when the output
// does not stall; an item opening the stream adds the stream and block headers, one
// opening a block mid-stream the block header, and the last byte of a stream the trailer,
// all paced by the single output byte lane. The input stage takes a new item while the
// previous burst is still being sent. The user writes total_length via cfg_wr_en and
// cfg_wr_data only while the block is idle, unchecked by the block; zero counts as one.

module zlib_stored_block_framer
	import zsbf_pkg::*;
#(
	parameter logic [15:0] BLOCK_BYTES = ZSBF_BLOCK_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data,
	zsbf_in_if.sink      raw,
	zsbf_out_if.source   zstream
);

	// configuration and running stream state
	logic [31:0] total_len_q;
	logic [31:0] bytes_done_q;
	logic [15:0] blk_rem_q;
	logic [15:0] sum_lo_q;
	logic [15:0] sum_hi_q;

	// input stage: one framed item waiting for the sequencer
	logic   valid_s1;
	burst_t burst_s1;

	// sequencer stage: burst being sent
	logic   valid_s2;
	burst_t burst_s2;
	phase_t phase_s2;

	logic   in_acc;
	logic   out_acc;
	logic   last_s2;
	logic   load_s2;

	// framing logic for the item at the input
	logic [31:0] total;
	logic [31:0] owed;
	logic [15:0] len;
	logic        bhdr;
	logic        bfinal;
	logic [16:0] lo_sum;
	logic [15:0] lo_new;
	logic [16:0] hi_sum;
	logic [15:0] hi_new;
	logic [31:0] done_new;
	logic [15:0] rem_cur;
	logic        stream_done;
	burst_t      burst_new;

	always_comb begin
		total  = (total_len_q == 32'd0) ? 32'd1 : total_len_q;
		bhdr   = (blk_rem_q == 16'd0);
		// a length already reached at block start opens a final one-byte block
		owed   = (total > bytes_done_q) ? (total - bytes_done_q) : 32'd1;
		len    = (owed < {16'd0, BLOCK_BYTES}) ? owed[15:0] : BLOCK_BYTES;
		bfinal = ({16'd0, len} == owed);

		// adler-32, both sums stay below the modulus so one subtract suffices
		lo_sum = {1'b0, sum_lo_q} + {9'd0, raw.data_byte};
		lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
		hi_sum = {1'b0, sum_hi_q} + {1'b0, lo_new};
		hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

		done_new    = bytes_done_q + 32'd1;
		rem_cur     = bhdr ? len : blk_rem_q;
		// counter wrap also ends the stream
		stream_done = (done_new >= total) || (done_new == 32'd0);

		burst_new.shdr    = (bytes_done_q == 32'd0);
		burst_new.bhdr    = bhdr;
		burst_new.bfinal  = bfinal;
		burst_new.len     = len;
		burst_new.data    = raw.data_byte;
		burst_new.trailer = stream_done;
		burst_new.adl_hi  = hi_new;
		burst_new.adl_lo  = lo_new;
	end

	// handshakes
	assign last_s2   = (phase_s2 == PH_ADL0) || ((phase_s2 == PH_DATA) && !burst_s2.trailer);
	assign out_acc   = zstream.valid && zstream.ready;
	assign load_s2   = valid_s1 && (!valid_s2 || (out_acc && last_s2));
	assign raw.ready = !valid_s1 || load_s2;
	assign in_acc    = raw.valid && raw.ready;

	// stream state advances when the item is taken in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q  <= 32'd1;
			bytes_done_q <= 32'd0;
			blk_rem_q    <= 16'd0;
			sum_lo_q     <= 16'd1;
			sum_hi_q     <= 16'd0;
		end else begin
			if (cfg_wr_en)
				total_len_q <= cfg_wr_data;
			if (in_acc) begin
				if (stream_done) begin
					// open block cut short, everything back to stream start
					bytes_done_q <= 32'd0;
					blk_rem_q    <= 16'd0;
					sum_lo_q     <= 16'd1;
					sum_hi_q     <= 16'd0;
				end else begin
					bytes_done_q <= done_new;
					blk_rem_q    <= rem_cur - 16'd1;
					sum_lo_q     <= lo_new;
					sum_hi_q     <= hi_new;
				end
			end
		end
	end

	// stage valids and sequencer phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_s2 <= PH_HDR0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;

			if (load_s2) begin
				valid_s2 <= 1'b1;
				phase_s2 <= first_phase(burst_s1);
			end else if (out_acc) begin
				if (last_s2)
					valid_s2 <= 1'b0;
				else
					phase_s2 <= next_phase(phase_s2, burst_s2);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc)
			burst_s1 <= burst_new;
		if (load_s2)
			burst_s2 <= burst_s1;
	end

	// output byte select
	logic [15:0] nlen_s2;
	assign nlen_s2 = ~burst_s2.len;

	always_comb begin
		case (phase_s2)
			PH_HDR0:  zstream.out_byte = ZLIB_CMF;
			PH_HDR1:  zstream.out_byte = ZLIB_FLG;
			PH_FLAG:  zstream.out_byte = burst_s2.bfinal ? BFINAL_SET : BFINAL_CLEAR;
			PH_LEN0:  zstream.out_byte = burst_s2.len[7:0];
			PH_LEN1:  zstream.out_byte = burst_s2.len[15:8];
			PH_NLEN0: zstream.out_byte = nlen_s2[7:0];
			PH_NLEN1: zstream.out_byte = nlen_s2[15:8];
			PH_DATA:  zstream.out_byte = burst_s2.data;
			PH_ADL3:  zstream.out_byte = burst_s2.adl_hi[15:8];
			PH_ADL2:  zstream.out_byte = burst_s2.adl_hi[7:0];
			PH_ADL1:  zstream.out_byte = burst_s2.adl_lo[15:8];
			PH_ADL0:  zstream.out_byte = burst_s2.adl_lo[7:0];
			default:  zstream.out_byte = burst_s2.data;
		endcase
	end

	assign zstream.valid      = valid_s2;
	assign zstream.run_last   = last_s2;
	assign zstream.stream_end = (phase_s2 == PH_ADL0);

`ifndef SYNTHESIS
	// adler sums never reach the modulus
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, sum_lo_q} < ADLER_MOD) && ({1'b0, sum_hi_q} < ADLER_MOD))
		else $error("adler sum out of range");

	// a stalled output byte keeps its place in the burst
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !zstream.ready |=> valid_s2 && $stable(phase_s2))
		else $error("sequencer moved while stalled");

	// stream end is always the last byte of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		zstream.valid && zstream.stream_end |-> zstream.run_last)
		else $error("stream end not on last byte");

	// a finished stream leaves the counters at stream start
	a_reset_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && stream_done |=> (bytes_done_q == 32'd0) && (blk_rem_q == 16'd0))
		else $error("counters not cleared after stream end");
`endif

endmodule
